@@ src/qstv_pkg.sv @@
package qstv_pkg;

  localparam int VEC_W    = 32;
  localparam int ROT_W    = 16;
  localparam int SCL_W    = 16;
  localparam int OFF_W    = 32;
  localparam int CFG_W    = 48;
  localparam int IDX_W    = 3;
  localparam int AXES     = 3;

  localparam int FRAC_S   = 8;
  localparam int FRAC_Q   = 14;

  // intermediate widths, sized from operand ranges
  localparam int PROD_S_W = VEC_W + SCL_W;
  localparam int P_W      = 40;
  localparam int QP_W     = 56;
  localparam int T_W      = 42;
  localparam int QT_W     = 58;
  localparam int U_W      = 44;
  localparam int WT_W     = 43;
  localparam int SUM_W    = 48;

  localparam int STAGES   = 7;

  localparam int NXT1 [AXES] = '{1, 2, 0};
  localparam int NXT2 [AXES] = '{2, 0, 1};

  typedef enum logic [IDX_W-1:0] {
    REG_ROT_W    = 3'd0,
    REG_ROT_X    = 3'd1,
    REG_ROT_Y    = 3'd2,
    REG_ROT_Z    = 3'd3,
    REG_SCALE    = 3'd4,
    REG_OFFSET_X = 3'd5,
    REG_OFFSET_Y = 3'd6,
    REG_OFFSET_Z = 3'd7
  } reg_idx_t;

  typedef enum logic {
    CMD_POINT     = 1'b0,
    CMD_DIRECTION = 1'b1
  } cmd_t;

  typedef struct packed {
    logic [ROT_W-1:0]            rot_w;
    logic [AXES-1:0][ROT_W-1:0]  rot_q;
    logic [AXES-1:0][SCL_W-1:0]  scale;
    logic [AXES-1:0][OFF_W-1:0]  offset;
  } cfg_t;

  localparam logic [ROT_W-1:0] ROT_W_RESET = 16'd16384;
  localparam logic [SCL_W-1:0] SCALE_ONE   = 16'h0100;

endpackage

@@ src/quaternion_scale_translate_vector_unit.sv @@
// Throughput: one request per cycle while m_tready does not hold the chain;
// seven register stages (scale multiply, round, two cross-product
// multiply/round pairs, sum and saturate).
// Each stage holds under back-pressure; bubbles close up as the chain drains.
// rst is synchronous: pipeline emptied, identity rotation, unit scale, zero offset.
module quaternion_scale_translate_vector_unit (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    s_tvalid,
  output logic                                    s_tready,
  input  logic [3*qstv_pkg::VEC_W-1:0]            s_tdata,  // vec_x, vec_y, vec_z
  input  logic                                    s_tuser,  // command
  output logic                                    m_tvalid,
  input  logic                                    m_tready,
  output logic [3*qstv_pkg::VEC_W-1:0]            m_tdata,  // out_x, out_y, out_z
  output logic                                    m_tuser,  // clipped
  input  logic                                    cfg_we,
  input  logic [qstv_pkg::IDX_W-1:0]              cfg_index,
  input  logic [qstv_pkg::CFG_W-1:0]              cfg_data
);

  localparam int N  = qstv_pkg::STAGES;
  localparam int NA = qstv_pkg::AXES;

  qstv_pkg::cfg_t cfg;

  qstv_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  logic [N-1:0] vld;
  logic [N-1:0] rdy;

  always_comb begin
    rdy[N-1] = !vld[N-1] || m_tready;
    for (int k = N - 2; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign s_tready = rdy[0];
  assign m_tvalid = vld[N-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= s_tvalid;
      end
      for (int k = 1; k < N; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  logic signed [qstv_pkg::ROT_W-1:0] qw;
  logic signed [qstv_pkg::ROT_W-1:0] qv [NA];
  logic signed [qstv_pkg::SCL_W-1:0] sc [NA];
  logic signed [qstv_pkg::OFF_W-1:0] of [NA];

  always_comb begin
    qw = $signed(cfg.rot_w);
    for (int i = 0; i < NA; i++) begin
      qv[i] = $signed(cfg.rot_q[i]);
      sc[i] = $signed(cfg.scale[i]);
      of[i] = $signed(cfg.offset[i]);
    end
  end

  // stage registers
  logic signed [qstv_pkg::PROD_S_W-1:0] prod1 [NA];
  logic signed [qstv_pkg::P_W-1:0]      p2 [NA], p3 [NA], p4 [NA], p5 [NA], p6 [NA];
  logic signed [qstv_pkg::QP_W-1:0]     qp3 [2*NA];
  logic signed [qstv_pkg::T_W-1:0]      t4 [NA];
  logic signed [qstv_pkg::QT_W-1:0]     qt5 [2*NA];
  logic signed [qstv_pkg::QT_W-1:0]     wt5 [NA];
  logic signed [qstv_pkg::U_W-1:0]      u6 [NA];
  logic signed [qstv_pkg::WT_W-1:0]     wr6 [NA];
  logic [N-2:0]                         cmd;

  logic signed [qstv_pkg::VEC_W-1:0]    vin [NA];
  logic signed [qstv_pkg::PROD_S_W-1:0] ps_tmp [NA];
  logic signed [qstv_pkg::QP_W-1:0]     qp_tmp [NA];
  logic signed [qstv_pkg::QT_W-1:0]     qt_tmp [NA];
  logic signed [qstv_pkg::QT_W-1:0]     wt_tmp [NA];
  logic signed [qstv_pkg::SUM_W-1:0]    r [NA];
  logic [NA-1:0]                        sat;
  logic [3*qstv_pkg::VEC_W-1:0]         out_data;

  always_comb begin
    for (int i = 0; i < NA; i++) begin
      vin[i] = $signed(s_tdata[i*qstv_pkg::VEC_W +: qstv_pkg::VEC_W]);

      ps_tmp[i] = prod1[i] + qstv_pkg::PROD_S_W'(1 << (qstv_pkg::FRAC_S - 1));
      qp_tmp[i] = qp3[2*i] - qp3[2*i+1];
      qp_tmp[i] = qp_tmp[i] + qstv_pkg::QP_W'(1 << (qstv_pkg::FRAC_Q - 1));
      qt_tmp[i] = qt5[2*i] - qt5[2*i+1];
      qt_tmp[i] = qt_tmp[i] + qstv_pkg::QT_W'(1 << (qstv_pkg::FRAC_Q - 1));
      wt_tmp[i] = wt5[i] + qstv_pkg::QT_W'(1 << (qstv_pkg::FRAC_Q - 1));

      r[i] = qstv_pkg::SUM_W'(p6[i])
           + ((qstv_pkg::SUM_W'(wr6[i]) + qstv_pkg::SUM_W'(u6[i])) <<< 1);
      if (qstv_pkg::cmd_t'(cmd[N-2]) == qstv_pkg::CMD_POINT) begin
        r[i] = r[i] + qstv_pkg::SUM_W'(of[i]);
      end

      sat[i] = (r[i][qstv_pkg::SUM_W-1:qstv_pkg::VEC_W-1] != '0)
            && (r[i][qstv_pkg::SUM_W-1:qstv_pkg::VEC_W-1] != '1);
      if (!sat[i]) begin
        out_data[i*qstv_pkg::VEC_W +: qstv_pkg::VEC_W] = r[i][qstv_pkg::VEC_W-1:0];
      end else if (r[i][qstv_pkg::SUM_W-1]) begin
        out_data[i*qstv_pkg::VEC_W +: qstv_pkg::VEC_W] = {1'b1, {(qstv_pkg::VEC_W-1){1'b0}}};
      end else begin
        out_data[i*qstv_pkg::VEC_W +: qstv_pkg::VEC_W] = {1'b0, {(qstv_pkg::VEC_W-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      cmd[0] <= s_tuser;
      for (int i = 0; i < NA; i++) begin
        prod1[i] <= qstv_pkg::PROD_S_W'(vin[i]) * qstv_pkg::PROD_S_W'(sc[i]);
      end
    end
    if (rdy[1]) begin
      cmd[1] <= cmd[0];
      for (int i = 0; i < NA; i++) begin
        p2[i] <= qstv_pkg::P_W'(ps_tmp[i] >>> qstv_pkg::FRAC_S);
      end
    end
    // q x p
    if (rdy[2]) begin
      cmd[2] <= cmd[1];
      for (int i = 0; i < NA; i++) begin
        p3[i]      <= p2[i];
        qp3[2*i]   <= qstv_pkg::QP_W'(qv[qstv_pkg::NXT1[i]])
                    * qstv_pkg::QP_W'(p2[qstv_pkg::NXT2[i]]);
        qp3[2*i+1] <= qstv_pkg::QP_W'(qv[qstv_pkg::NXT2[i]])
                    * qstv_pkg::QP_W'(p2[qstv_pkg::NXT1[i]]);
      end
    end
    if (rdy[3]) begin
      cmd[3] <= cmd[2];
      for (int i = 0; i < NA; i++) begin
        p4[i] <= p3[i];
        t4[i] <= qstv_pkg::T_W'(qp_tmp[i] >>> qstv_pkg::FRAC_Q);
      end
    end
    // q x t and w * t
    if (rdy[4]) begin
      cmd[4] <= cmd[3];
      for (int i = 0; i < NA; i++) begin
        p5[i]      <= p4[i];
        qt5[2*i]   <= qstv_pkg::QT_W'(qv[qstv_pkg::NXT1[i]])
                    * qstv_pkg::QT_W'(t4[qstv_pkg::NXT2[i]]);
        qt5[2*i+1] <= qstv_pkg::QT_W'(qv[qstv_pkg::NXT2[i]])
                    * qstv_pkg::QT_W'(t4[qstv_pkg::NXT1[i]]);
        wt5[i]     <= qstv_pkg::QT_W'(qw) * qstv_pkg::QT_W'(t4[i]);
      end
    end
    if (rdy[5]) begin
      cmd[5] <= cmd[4];
      for (int i = 0; i < NA; i++) begin
        p6[i]  <= p5[i];
        u6[i]  <= qstv_pkg::U_W'(qt_tmp[i] >>> qstv_pkg::FRAC_Q);
        wr6[i] <= qstv_pkg::WT_W'(wt_tmp[i] >>> qstv_pkg::FRAC_Q);
      end
    end
    if (rdy[6]) begin
      m_tdata <= out_data;
      m_tuser <= |sat;
    end
  end

  a_bubble_ready: assert property (@(posedge clk) disable iff (rst)
    !vld[0] |-> s_tready)
    else $error("input stalled with an empty first stage");

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    vld[N-2] && !rdy[N-1] |=> vld[N-2] && $stable(cmd[N-2]) && $stable(u6[0]))
    else $error("stalled stage lost or changed its request");

  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(vld[N-2]))
    else $error("result appeared with no request behind it");

  a_clip_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |->
      (m_tdata[31:0] == 32'h7fffffff) || (m_tdata[31:0] == 32'h80000000) ||
      (m_tdata[63:32] == 32'h7fffffff) || (m_tdata[63:32] == 32'h80000000) ||
      (m_tdata[95:64] == 32'h7fffffff) || (m_tdata[95:64] == 32'h80000000))
    else $error("clipped flagged with no component at a bound");

endmodule

@@ src/qstv_regs.sv @@
module qstv_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [qstv_pkg::IDX_W-1:0]    cfg_index,
  input  logic [qstv_pkg::CFG_W-1:0]    cfg_data,
  output qstv_pkg::cfg_t                cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rot_w  <= qstv_pkg::ROT_W_RESET;
      cfg.rot_q  <= '0;
      cfg.scale  <= {qstv_pkg::AXES{qstv_pkg::SCALE_ONE}};
      cfg.offset <= '0;
    end else if (cfg_we) begin
      unique case (qstv_pkg::reg_idx_t'(cfg_index))
        qstv_pkg::REG_ROT_W:    cfg.rot_w     <= cfg_data[qstv_pkg::ROT_W-1:0];
        qstv_pkg::REG_ROT_X:    cfg.rot_q[0]  <= cfg_data[qstv_pkg::ROT_W-1:0];
        qstv_pkg::REG_ROT_Y:    cfg.rot_q[1]  <= cfg_data[qstv_pkg::ROT_W-1:0];
        qstv_pkg::REG_ROT_Z:    cfg.rot_q[2]  <= cfg_data[qstv_pkg::ROT_W-1:0];
        qstv_pkg::REG_SCALE:    cfg.scale     <= cfg_data;
        qstv_pkg::REG_OFFSET_X: cfg.offset[0] <= cfg_data[qstv_pkg::OFF_W-1:0];
        qstv_pkg::REG_OFFSET_Y: cfg.offset[1] <= cfg_data[qstv_pkg::OFF_W-1:0];
        qstv_pkg::REG_OFFSET_Z: cfg.offset[2] <= cfg_data[qstv_pkg::OFF_W-1:0];
      endcase
    end
  end

endmodule
